FILE: hw/rtl/nlsa_pkg.sv
// shared types, constants and the table lookup helper for the nibble lookup score accumulator
// no dependencies
package nlsa_pkg;

  localparam int LANES       = 32;
  localparam int HALF_LANES  = LANES / 2;
  localparam int LANE_W      = $clog2(LANES);
  localparam int CNT_W       = $clog2(LANES + 1);
  localparam int SCORE_W     = 32;
  localparam int VAL_W       = 8;
  localparam int CODE_W      = 4;
  localparam int TABLE_W     = 128;
  localparam int CELL_W      = 128;
  localparam int IN_TDATA_W  = 256;
  localparam int OUT_TDATA_W = 40;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [LANES-1:0][VAL_W-1:0] vals;
    logic                        last;
  } entry_t;

  function automatic logic [VAL_W-1:0] lut_pick(input logic [TABLE_W-1:0] lut,
                                                input logic [CODE_W-1:0]  code);
    lut_pick = lut[code*VAL_W +: VAL_W];
  endfunction

endpackage

FILE: hw/rtl/nlsa_front.sv
// front end: takes input items, looks up the table byte of every lane, registers the entry
// depends on nlsa_pkg
module nlsa_front
  import nlsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TABLE_W-1:0]    lut,
  input  logic [CELL_W-1:0]     codes,
  input  logic                  last,
  output logic                  ent_valid,
  input  logic                  ent_ready,
  output entry_t                ent
);

  entry_t ent_r, ent_nxt;
  logic   valid_r, valid_nxt;
  logic   take;

  always_comb begin
    ent_nxt.last = last;
    for (int j = 0; j < HALF_LANES; j++) begin
      ent_nxt.vals[j]              = lut_pick(lut, codes[j*VAL_W +: CODE_W]);
      ent_nxt.vals[j + HALF_LANES] = lut_pick(lut, codes[j*VAL_W + CODE_W +: CODE_W]);
    end
  end

  assign in_ready  = !valid_r || ent_ready;
  assign take      = in_valid && in_ready;
  assign ent_valid = valid_r;
  assign ent       = ent_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (ent_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

FILE: hw/rtl/nlsa_queue.sv
// two-entry item queue between the lookup front end and the accumulator back end
// depends on nlsa_pkg
module nlsa_queue
  import nlsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_ent,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_ent
);

  entry_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push, pop;

  assign push_ready = count_r != QCNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_ent    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

FILE: hw/rtl/nlsa_back.sv
// back end: per-lane accumulators, drain buffer for finished blocks and the output register
// depends on nlsa_pkg
module nlsa_back
  import nlsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ent_valid,
  output logic               ent_ready,
  input  entry_t             ent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LANE_W-1:0]  out_lane,
  output logic [SCORE_W-1:0] out_score,
  output logic               out_last
);

  logic [SCORE_W-1:0] acc_r   [LANES];
  logic [SCORE_W-1:0] drain_r [LANES];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy, pop, emit;
  logic [CNT_W-1:0]   lane_full;

  logic               ov_r, ov_nxt;
  logic [LANE_W-1:0]  lane_r;
  logic [SCORE_W-1:0] score_r;
  logic               last_r;

  assign busy      = cnt_r != '0;
  assign ent_ready = !ent.last || !busy;
  assign pop       = ent_valid && ent_ready;
  assign emit      = busy && (!ov_r || out_ready);
  assign lane_full = CNT_W'(LANES) - cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (pop && ent.last) begin
      cnt_nxt = CNT_W'(LANES);
    end else if (emit) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
      for (int j = 0; j < LANES; j++) begin
        acc_r[j] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
      if (pop) begin
        for (int j = 0; j < LANES; j++) begin
          acc_r[j] <= ent.last ? '0 : acc_r[j] + SCORE_W'(ent.vals[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ent.last) begin
      for (int j = 0; j < LANES; j++) begin
        drain_r[j] <= acc_r[j] + SCORE_W'(ent.vals[j]);
      end
    end else if (emit) begin
      for (int j = 0; j < LANES - 1; j++) begin
        drain_r[j] <= drain_r[j+1];
      end
    end
    if (emit) begin
      lane_r  <= lane_full[LANE_W-1:0];
      score_r <= drain_r[0];
      last_r  <= cnt_r == CNT_W'(1);
    end
  end

  assign out_valid = ov_r;
  assign out_lane  = lane_r;
  assign out_score = score_r;
  assign out_last  = last_r;

endmodule

FILE: hw/rtl/nibble_lut_score_accumulator_unit.sv
// top level of the nibble lookup score accumulator: front end, item queue and back end
// depends on nlsa_pkg, nlsa_front, nlsa_queue and nlsa_back
//
// Scores a block of 32 vectors with 4-bit codes, one coordinate per input item, and
// takes one item per clock cycle unless the queue or the back end stalls it. Each
// item's 32 table lookups are done in the front stage; the accumulators add them after
// the front register and a two-entry queue. On the item marked tlast the 32 lane scores
// are copied into a drain buffer, the accumulators start again from zero, and the scores
// leave one per cycle in lane order through the output register while out_tready allows.
// Items of the next block keep streaming in meanwhile; only its own last item waits at
// the queue head until the previous drain is finished. The first score of a block goes
// from the front register through the queue and the drain buffer to the output register.
module nibble_lut_score_accumulator_unit
  import nlsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // lut_low, lut_high, codes_low, codes_high
  input  logic                   in_tlast,   // last_coordinate
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // lane, score, zero fill
  output logic                   out_tlast   // last_of_block
);

  logic               f_valid, f_ready;
  entry_t             f_ent;
  logic               q_valid, q_ready;
  entry_t             q_ent;
  logic [LANE_W-1:0]  lane;
  logic [SCORE_W-1:0] score;

  nlsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .lut       (in_tdata[TABLE_W-1:0]),
    .codes     (in_tdata[TABLE_W +: CELL_W]),
    .last      (in_tlast),
    .ent_valid (f_valid),
    .ent_ready (f_ready),
    .ent       (f_ent)
  );

  nlsa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_ent   (f_ent),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_ent    (q_ent)
  );

  nlsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (q_valid),
    .ent_ready (q_ready),
    .ent       (q_ent),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_lane  (lane),
    .out_score (score),
    .out_last  (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - LANE_W - SCORE_W)'(0), score, lane};

endmodule
